FILE: rtl/ps2d_pkg.sv
// shared package for the ps/2 set 2 scan code decoder
// holds key codes, layout tables, ring pointer helper and the command format
// no dependencies
package ps2d_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_RECV      = 2'd0,
    FUNC_POP_ASCII = 2'd1,
    FUNC_POP_CODE  = 2'd2
  } func_t;

  // scan codes with special meaning
  localparam logic [7:0] KC_RELEASE  = 8'hF0;
  localparam logic [7:0] KC_EXTENDED = 8'hE0;
  localparam logic [7:0] KC_LSHIFT   = 8'h12;
  localparam logic [7:0] KC_RSHIFT   = 8'h59;
  localparam logic [7:0] KC_CTRL     = 8'h14;
  localparam logic [7:0] KC_ALT      = 8'h11;
  localparam logic [7:0] KC_SCROLL   = 8'h7E;
  localparam logic [7:0] KC_NUM      = 8'h77;
  localparam logic [7:0] KC_CAPS     = 8'h58;
  localparam logic [7:0] KC_UP       = 8'h75;
  localparam logic [7:0] KC_LEFT     = 8'h6B;
  localparam logic [7:0] KC_DOWN     = 8'h72;
  localparam logic [7:0] KC_RIGHT    = 8'h74;
  localparam logic [7:0] KC_KP_DOT   = 8'h71;

  localparam logic [7:0] ASCII_DEL   = 8'h7F;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;

  typedef struct packed {
    logic [1:0] last_error;
    logic [2:0] led_bits;
    logic [3:0] arrow_keys;
    logic [2:0] modifier_keys;
  } status_t;

  // one decoded item on its way to the back end
  typedef struct packed {
    logic             pop_en;     // pop hit a stored byte
    logic             pop_ascii;  // 1 ascii store, 0 code store
    logic [PTR_W-1:0] rd_addr;
    logic             a_wr;
    logic [PTR_W-1:0] a_addr;
    logic [7:0]       a_data;
    logic             c_wr;
    logic [PTR_W-1:0] c_addr;
    logic [7:0]       c_data;
    logic             led_request;
    status_t          status;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // german layout: {plain, shifted}, zero when the code is not in the layout
  function automatic logic [15:0] key_ascii_pair(input logic [6:0] idx);
    case (idx)
      7'h79: key_ascii_pair = {"+", "+"};
      7'h7B: key_ascii_pair = {"-", "-"};
      7'h7C: key_ascii_pair = {"*", "*"};
      7'h4A: key_ascii_pair = {"/", "/"};
      7'h5A: key_ascii_pair = {8'h0D, 8'h0D};
      7'h66: key_ascii_pair = {8'h08, 8'h08};
      7'h29: key_ascii_pair = {" ", " "};
      7'h41: key_ascii_pair = {",", ";"};
      7'h5B: key_ascii_pair = {"+", "*"};
      7'h4E: key_ascii_pair = {"-", "_"};
      7'h49: key_ascii_pair = {".", ":"};
      7'h1C: key_ascii_pair = {"a", "A"};
      7'h32: key_ascii_pair = {"b", "B"};
      7'h21: key_ascii_pair = {"c", "C"};
      7'h23: key_ascii_pair = {"d", "D"};
      7'h24: key_ascii_pair = {"e", "E"};
      7'h2B: key_ascii_pair = {"f", "F"};
      7'h34: key_ascii_pair = {"g", "G"};
      7'h33: key_ascii_pair = {"h", "H"};
      7'h43: key_ascii_pair = {"i", "I"};
      7'h3B: key_ascii_pair = {"j", "J"};
      7'h42: key_ascii_pair = {"k", "K"};
      7'h4B: key_ascii_pair = {"l", "L"};
      7'h3A: key_ascii_pair = {"m", "M"};
      7'h31: key_ascii_pair = {"n", "N"};
      7'h44: key_ascii_pair = {"o", "O"};
      7'h4D: key_ascii_pair = {"p", "P"};
      7'h15: key_ascii_pair = {"q", "Q"};
      7'h2D: key_ascii_pair = {"r", "R"};
      7'h1B: key_ascii_pair = {"s", "S"};
      7'h2C: key_ascii_pair = {"t", "T"};
      7'h3C: key_ascii_pair = {"u", "U"};
      7'h2A: key_ascii_pair = {"v", "V"};
      7'h1D: key_ascii_pair = {"w", "W"};
      7'h22: key_ascii_pair = {"x", "X"};
      7'h35: key_ascii_pair = {"z", "Z"};
      7'h1A: key_ascii_pair = {"y", "Y"};
      7'h45: key_ascii_pair = {"0", "="};
      7'h16: key_ascii_pair = {"1", "!"};
      7'h1E: key_ascii_pair = {"2", 8'h22};
      7'h26: key_ascii_pair = {"3", 8'hA7};
      7'h25: key_ascii_pair = {"4", "$"};
      7'h2E: key_ascii_pair = {"5", "%"};
      7'h36: key_ascii_pair = {"6", "&"};
      7'h3D: key_ascii_pair = {"7", "/"};
      7'h3E: key_ascii_pair = {"8", "("};
      7'h46: key_ascii_pair = {"9", ")"};
      7'h0E: key_ascii_pair = {"#", 8'h27};
      7'h55: key_ascii_pair = {"=", "?"};
      7'h5D: key_ascii_pair = {8'h5C, "?"};
      default: key_ascii_pair = 16'h0000;
    endcase
  endfunction

  // keypad digits, zero when not a keypad digit
  function automatic logic [7:0] keypad_ascii(input logic [6:0] idx);
    case (idx)
      7'h70: keypad_ascii = "0";
      7'h69: keypad_ascii = "1";
      7'h72: keypad_ascii = "2";
      7'h7A: keypad_ascii = "3";
      7'h6B: keypad_ascii = "4";
      7'h73: keypad_ascii = "5";
      7'h74: keypad_ascii = "6";
      7'h6C: keypad_ascii = "7";
      7'h75: keypad_ascii = "8";
      7'h7D: keypad_ascii = "9";
      default: keypad_ascii = 8'h00;
    endcase
  endfunction

endpackage

FILE: rtl/ps2d_if.sv
// channel interfaces of the scan code decoder: input items and result items
// valid/ready handshake with the payload alongside, no dependencies
interface ps2d_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] scan_byte;
  logic       line_error;

  modport source (output valid, output func, output scan_byte, output line_error,
                  input ready);
  modport sink   (input valid, input func, input scan_byte, input line_error,
                  output ready);
endinterface

interface ps2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [1:0] last_error;
  logic       led_request;
  logic [2:0] led_bits;
  logic [3:0] arrow_keys;
  logic [2:0] modifier_keys;

  modport source (output valid, output read_data, output read_valid, output last_error,
                  output led_request, output led_bits, output arrow_keys,
                  output modifier_keys, input ready);
  modport sink   (input valid, input read_data, input read_valid, input last_error,
                  input led_request, input led_bits, input arrow_keys,
                  input modifier_keys, output ready);
endinterface

FILE: rtl/ps2d_front.sv
// front end: accepts items, tracks key marks, flags and ring pointers
// and issues one command per item; depends on ps2d_pkg and ps2d_if
module ps2d_front (
  input  logic            clk,
  input  logic            rst_n,
  ps2d_in_if.sink         in_chan,
  input  logic            q_full,
  output logic            q_wr,
  output ps2d_pkg::cmd_t  q_cmd
);
  import ps2d_pkg::*;

  logic             rel_r, rel_nxt;
  logic             ext_r, ext_nxt;
  logic [2:0]       mod_r, mod_nxt;
  logic [2:0]       lock_r, lock_nxt;
  logic             ledp_r, ledp_nxt;
  logic [3:0]       arrow_r, arrow_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [PTR_W-1:0] a_head_r, a_head_nxt, a_tail_r, a_tail_nxt;
  logic [PTR_W-1:0] c_head_r, c_head_nxt, c_tail_r, c_tail_nxt;

  logic             acc;
  logic [7:0]       b;
  logic             make;
  logic             not_flag_key;
  logic             plain;
  logic [7:0]       ch;
  logic [7:0]       kp;
  logic [15:0]      km;
  logic             sh;
  logic [PTR_W-1:0] a_nh, c_nh;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && !q_full;
  assign q_wr          = acc;

  assign b    = in_chan.scan_byte;
  assign make = !(rel_r | b[7]);
  assign kp   = keypad_ascii(b[6:0]);
  assign km   = key_ascii_pair(b[6:0]);
  assign sh   = mod_r[0] ^ lock_r[2];
  assign a_nh = ring_next(a_head_r);
  assign c_nh = ring_next(c_head_r);

  always_comb begin
    rel_nxt      = rel_r;
    ext_nxt      = ext_r;
    mod_nxt      = mod_r;
    lock_nxt     = lock_r;
    ledp_nxt     = ledp_r;
    arrow_nxt    = arrow_r;
    err_nxt      = err_r;
    a_head_nxt   = a_head_r;
    a_tail_nxt   = a_tail_r;
    c_head_nxt   = c_head_r;
    c_tail_nxt   = c_tail_r;
    not_flag_key = 1'b0;
    plain        = 1'b0;
    ch           = 8'h00;
    q_cmd        = '0;

    if (acc) begin
      case (in_chan.func)
        FUNC_RECV: begin
          rel_nxt = 1'b0;
          case (b)
            KC_RELEASE:           rel_nxt = 1'b1;
            KC_EXTENDED:          ext_nxt = make;
            KC_LSHIFT, KC_RSHIFT: mod_nxt[0] = make;
            KC_CTRL:              mod_nxt[1] = make;
            KC_ALT:               mod_nxt[2] = make;
            KC_SCROLL: begin
              if (make) begin
                lock_nxt[0] = ~lock_r[0];
                ledp_nxt    = 1'b1;
              end
            end
            KC_NUM: begin
              if (make) begin
                lock_nxt[1] = ~lock_r[1];
                ledp_nxt    = 1'b1;
              end
            end
            KC_CAPS: begin
              if (make) begin
                lock_nxt[2] = ~lock_r[2];
                ledp_nxt    = 1'b1;
              end
            end
            default: not_flag_key = 1'b1;
          endcase

          // keypad arrows only while num lock is off
          if (not_flag_key) begin
            if (!lock_r[1]) begin
              case (b)
                KC_UP:    arrow_nxt[0] = make;
                KC_LEFT:  arrow_nxt[1] = make;
                KC_DOWN:  arrow_nxt[2] = make;
                KC_RIGHT: arrow_nxt[3] = make;
                default:  plain = 1'b1;
              endcase
            end else begin
              plain = 1'b1;
            end
          end

          if (plain) begin
            if (make) begin
              if (kp != 8'h00) begin
                ch = lock_r[1] ? kp : 8'h00;
              end else if (b == KC_KP_DOT) begin
                ch = (ext_r || !lock_r[1]) ? ASCII_DEL : ASCII_COMMA;
              end else if (km[15:8] != 8'h00) begin
                ch = sh ? km[7:0] : km[15:8];
              end else begin
                ch = b;
              end
            end
            err_nxt = {1'b0, in_chan.line_error};
            if (ch != 8'h00) begin
              if (a_nh != a_tail_r) begin
                a_head_nxt   = a_nh;
                q_cmd.a_wr   = 1'b1;
                q_cmd.a_addr = a_nh;
                q_cmd.a_data = ch;
              end else begin
                err_nxt[1] = 1'b1;
              end
            end
            if (c_nh != c_tail_r) begin
              c_head_nxt   = c_nh;
              q_cmd.c_wr   = 1'b1;
              q_cmd.c_addr = c_nh;
              q_cmd.c_data = b;
            end
          end
        end
        FUNC_POP_ASCII: begin
          q_cmd.led_request = ledp_r;
          ledp_nxt          = 1'b0;
          q_cmd.pop_ascii   = 1'b1;
          if (a_head_r != a_tail_r) begin
            a_tail_nxt    = ring_next(a_tail_r);
            q_cmd.pop_en  = 1'b1;
            q_cmd.rd_addr = ring_next(a_tail_r);
          end
        end
        FUNC_POP_CODE: begin
          q_cmd.led_request = ledp_r;
          ledp_nxt          = 1'b0;
          if (c_head_r != c_tail_r) begin
            c_tail_nxt    = ring_next(c_tail_r);
            q_cmd.pop_en  = 1'b1;
            q_cmd.rd_addr = ring_next(c_tail_r);
          end
        end
        default: ;
      endcase
    end

    // status as it stands after this item
    q_cmd.status.last_error    = err_nxt;
    q_cmd.status.led_bits      = lock_nxt;
    q_cmd.status.arrow_keys    = arrow_nxt;
    q_cmd.status.modifier_keys = mod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r    <= 1'b0;
      ext_r    <= 1'b0;
      mod_r    <= '0;
      lock_r   <= '0;
      ledp_r   <= 1'b0;
      arrow_r  <= '0;
      err_r    <= '0;
      a_head_r <= '0;
      a_tail_r <= '0;
      c_head_r <= '0;
      c_tail_r <= '0;
    end else begin
      rel_r    <= rel_nxt;
      ext_r    <= ext_nxt;
      mod_r    <= mod_nxt;
      lock_r   <= lock_nxt;
      ledp_r   <= ledp_nxt;
      arrow_r  <= arrow_nxt;
      err_r    <= err_nxt;
      a_head_r <= a_head_nxt;
      a_tail_r <= a_tail_nxt;
      c_head_r <= c_head_nxt;
      c_tail_r <= c_tail_nxt;
    end
  end

endmodule

FILE: rtl/ps2d_cmd_queue.sv
// short command queue between the front end and the back end
// depends on ps2d_pkg
module ps2d_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ps2d_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output ps2d_pkg::cmd_t rd_cmd,
  output logic           empty
);
  import ps2d_pkg::*;

  localparam logic [CQ_PTR_W-1:0] CQ_LAST = CQ_PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CQ_CNT_W-1:0] CQ_FULL = CQ_CNT_W'(CMDQ_DEPTH);

  cmd_t                slot_r [CMDQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full   = (cnt_r == CQ_FULL);
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == CQ_LAST) ? '0 : wr_ptr_r + CQ_PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == CQ_LAST) ? '0 : rd_ptr_r + CQ_PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + CQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/ps2d_back.sv
// back end: holds the ascii and scan code stores, carries out writes and
// reads in command order and drives the result register; depends on ps2d_pkg, ps2d_if
module ps2d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  ps2d_pkg::cmd_t q_cmd,
  output logic           q_rd,
  ps2d_out_if.source     out_chan
);
  import ps2d_pkg::*;

  logic [7:0] ascii_mem [FIFO_DEPTH];
  logic [7:0] code_mem  [FIFO_DEPTH];

  logic       out_valid_r;
  logic [7:0] read_data_r;
  logic       read_valid_r;
  logic       led_request_r;
  status_t    status_r;

  assign q_rd = !q_empty && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (q_rd && q_cmd.a_wr) begin
      ascii_mem[q_cmd.a_addr] <= q_cmd.a_data;
    end
    if (q_rd && q_cmd.c_wr) begin
      code_mem[q_cmd.c_addr] <= q_cmd.c_data;
    end
  end

  // registered read straight into the result register
  always_ff @(posedge clk) begin
    if (q_rd) begin
      if (!q_cmd.pop_en) begin
        read_data_r <= 8'h00;
      end else if (q_cmd.pop_ascii) begin
        read_data_r <= ascii_mem[q_cmd.rd_addr];
      end else begin
        read_data_r <= code_mem[q_cmd.rd_addr];
      end
      read_valid_r  <= q_cmd.pop_en;
      led_request_r <= q_cmd.led_request;
      status_r      <= q_cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.read_data     = read_data_r;
  assign out_chan.read_valid    = read_valid_r;
  assign out_chan.led_request   = led_request_r;
  assign out_chan.last_error    = status_r.last_error;
  assign out_chan.led_bits      = status_r.led_bits;
  assign out_chan.arrow_keys    = status_r.arrow_keys;
  assign out_chan.modifier_keys = status_r.modifier_keys;

endmodule

FILE: rtl/ps2d_scancode_to_ascii_decoder_core.sv
// PS/2 scan code set 2 decoder (german layout) with ascii and raw code rings.
// Every item, a received byte or a pop of either ring, gives exactly one
// result. The block takes one item per clock when the result side keeps up:
// the front end decodes a byte and updates the key flags and ring pointers
// as it accepts the item, and the back end performs at most one write or
// read on each ring memory per item. A result passes through the command
// queue and then the result register before it is presented; the two-entry
// command queue and the result register let both sides stall independently.
// Each ring keeps FIFO_DEPTH-1 bytes; a pop of an empty ring returns zero
// with read_valid low.
// depends on ps2d_pkg, ps2d_if, ps2d_front, ps2d_cmd_queue, ps2d_back
module ps2_scancode_to_ascii_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  ps2d_in_if.sink     in_chan,
  ps2d_out_if.source  out_chan
);
  import ps2d_pkg::*;

  logic q_wr, q_full, q_rd, q_empty;
  cmd_t q_wr_cmd, q_rd_cmd;

  ps2d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_cmd   (q_wr_cmd)
  );

  ps2d_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  ps2d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_rd_cmd),
    .q_rd     (q_rd),
    .out_chan (out_chan)
  );

endmodule
